@@ sv/fscd_pkg.sv @@
// fscd_pkg: shared types, constants and the CRC-32 byte update for the file segmenter.
// No dependencies; used by file_segmenter_crc32_descriptor.
package fscd_pkg;

    localparam int BUF_BYTES = 256;
    localparam int HDR_BYTES = 19;
    localparam int LIMIT_CAP_RAW = BUF_BYTES - HDR_BYTES;
    localparam int LIMIT_CAP = (LIMIT_CAP_RAW > 255) ? 255 : LIMIT_CAP_RAW;

    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    localparam logic [15:0] FILE_SIZE_RST = 16'd1;
    localparam logic [7:0]  FILE_TYPE_RST = 8'd4;
    localparam logic [7:0]  SEG_LIMIT_RST = 8'd200;

    localparam int ADDR_W = 4;

    typedef enum logic [1:0] {
        REG_FILE_SIZE = 2'd0,
        REG_FILE_TYPE = 2'd1,
        REG_SEG_LIMIT = 2'd2
    } reg_idx_t;

    typedef enum logic [1:0] {
        FT_START  = 2'd0,
        FT_MIDDLE = 2'd1,
        FT_END    = 2'd2
    } frame_t;

    typedef enum logic {
        KIND_DATA = 1'b0,
        KIND_DESC = 1'b1
    } kind_t;

    typedef struct packed {
        kind_t       item_kind;
        logic [7:0]  data_byte;
        frame_t      frame_type;
        logic [7:0]  desc_file_type;
        logic [15:0] desc_file_size;
        logic [15:0] seg_start;
        logic [7:0]  seg_length;
        logic [31:0] seg_crc;
        logic        last;
    } result_t;

    // reflected CRC-32, one byte, bit-serial over eight steps
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

@@ sv/file_segmenter_crc32_descriptor.sv @@
// file_segmenter_crc32_descriptor: splits a file byte stream into segments and emits a
// CRC-32 descriptor after each segment. Depends on fscd_pkg.
//
//  channel  | signals                                   | direction
//  ---------+-------------------------------------------+-----------
//  in       | in_valid, in_ready, payload_byte          | sink
//  out      | out_valid, out_ready, item_kind .. last   | source
//  cfg      | psel, penable, pwrite, paddr, pwdata, ... | APB slave
//
// One byte is taken per cycle while in_ready is high; its data result is registered the next cycle.
// A byte that closes a segment also queues a descriptor, which holds off the next input transfer
// until the descriptor has moved into the output register (two output transfers for that byte).
// Segment state and CRC update in the same cycle as the input transfer.
// Reset clears all state; configuration returns to file_size 1, file_type 4, seg_limit 200.
// A stalled output holds its result; input is taken only when the output slot frees up.
module file_segmenter_crc32_descriptor (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [7:0]                    payload_byte,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          item_kind,
    output logic [7:0]                    data_byte,
    output logic [1:0]                    frame_type,
    output logic [7:0]                    desc_file_type,
    output logic [15:0]                   desc_file_size,
    output logic [15:0]                   seg_start,
    output logic [7:0]                    seg_length,
    output logic [31:0]                   seg_crc,
    output logic                          last,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [fscd_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    logic [15:0] file_size_reg;
    logic [7:0]  file_type_reg;
    logic [7:0]  seg_limit_reg;

    logic [15:0]      file_pos_reg,   file_pos_next;
    logic [15:0]      cur_start_reg,  cur_start_next;
    logic [7:0]       cur_len_reg,    cur_len_next;
    logic [7:0]       cur_count_reg,  cur_count_next;
    fscd_pkg::frame_t cur_ft_reg,     cur_ft_next;
    logic [31:0]      crc_reg,        crc_next;

    fscd_pkg::result_t out_reg,  data_res;
    fscd_pkg::result_t desc_reg, desc_res;
    logic              out_valid_reg;
    logic              desc_pend_reg;

    logic              in_fire, out_fire, cfg_wr;
    fscd_pkg::reg_idx_t reg_idx;
    logic [15:0]       fsize;
    logic [7:0]        lim;
    logic [15:0]       pos0, remaining, pos_inc;
    logic [31:0]       crc_in, crc_upd;
    logic [7:0]        count_inc;
    logic              close;

    assign pready   = 1'b1;
    assign reg_idx  = fscd_pkg::reg_idx_t'(paddr[3:2]);
    assign cfg_wr   = psel && penable && pwrite;
    assign in_ready = !desc_pend_reg && (!out_valid_reg || out_ready);
    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid_reg && out_ready;

    always_comb
    begin
        unique case (reg_idx)
            fscd_pkg::REG_FILE_SIZE: prdata = {16'd0, file_size_reg};
            fscd_pkg::REG_FILE_TYPE: prdata = {24'd0, file_type_reg};
            fscd_pkg::REG_SEG_LIMIT: prdata = {24'd0, seg_limit_reg};
            default:                 prdata = 32'd0;
        endcase
    end

    always_comb
    begin
        fsize = (file_size_reg == 16'd0) ? 16'd1 : file_size_reg;
        if (seg_limit_reg == 8'd0)
            lim = 8'd1;
        else if (seg_limit_reg > 8'(fscd_pkg::LIMIT_CAP))
            lim = 8'(fscd_pkg::LIMIT_CAP);
        else
            lim = seg_limit_reg;

        pos0           = file_pos_reg;
        cur_start_next = cur_start_reg;
        cur_len_next   = cur_len_reg;
        cur_ft_next    = cur_ft_reg;
        crc_in         = crc_reg;
        remaining      = 16'd0;
        if (cur_count_reg == 8'd0)
        begin
            pos0           = (file_pos_reg >= fsize) ? 16'd0 : file_pos_reg;
            remaining      = fsize - pos0;
            cur_start_next = pos0;
            cur_len_next   = (remaining > {8'd0, lim}) ? lim : remaining[7:0];
            if (pos0 == 16'd0)
                cur_ft_next = fscd_pkg::FT_START;
            else if (remaining <= {8'd0, lim})
                cur_ft_next = fscd_pkg::FT_END;
            else
                cur_ft_next = fscd_pkg::FT_MIDDLE;
            crc_in = fscd_pkg::CRC_INIT;
        end

        crc_upd   = fscd_pkg::crc_byte(crc_in, payload_byte);
        count_inc = cur_count_reg + 8'd1;
        pos_inc   = pos0 + 16'd1;
        close     = (count_inc >= cur_len_next) || (pos_inc >= fsize);

        if (close)
        begin
            cur_count_next = 8'd0;
            crc_next       = fscd_pkg::CRC_INIT;
            file_pos_next  = (pos_inc >= fsize) ? 16'd0 : pos_inc;
        end
        else
        begin
            cur_count_next = count_inc;
            crc_next       = crc_upd;
            file_pos_next  = pos_inc;
        end

        data_res           = '0;
        data_res.item_kind = fscd_pkg::KIND_DATA;
        data_res.data_byte = payload_byte;
        data_res.last      = !close;

        desc_res                = '0;
        desc_res.item_kind      = fscd_pkg::KIND_DESC;
        desc_res.frame_type     = cur_ft_next;
        desc_res.desc_file_type = file_type_reg;
        desc_res.desc_file_size = fsize;
        desc_res.seg_start      = cur_start_next;
        desc_res.seg_length     = count_inc;
        desc_res.seg_crc        = ~crc_upd;
        desc_res.last           = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            file_size_reg <= fscd_pkg::FILE_SIZE_RST;
            file_type_reg <= fscd_pkg::FILE_TYPE_RST;
            seg_limit_reg <= fscd_pkg::SEG_LIMIT_RST;
            file_pos_reg  <= 16'd0;
            cur_start_reg <= 16'd0;
            cur_len_reg   <= 8'd0;
            cur_count_reg <= 8'd0;
            cur_ft_reg    <= fscd_pkg::FT_START;
            crc_reg       <= fscd_pkg::CRC_INIT;
            out_reg       <= '0;
            desc_reg      <= '0;
            out_valid_reg <= 1'b0;
            desc_pend_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
            begin
                unique case (reg_idx)
                    fscd_pkg::REG_FILE_SIZE: file_size_reg <= pwdata[15:0];
                    fscd_pkg::REG_FILE_TYPE: file_type_reg <= pwdata[7:0];
                    fscd_pkg::REG_SEG_LIMIT: seg_limit_reg <= pwdata[7:0];
                    default: ;
                endcase
            end

            if (in_fire)
            begin
                file_pos_reg  <= file_pos_next;
                cur_start_reg <= cur_start_next;
                cur_len_reg   <= cur_len_next;
                cur_count_reg <= cur_count_next;
                cur_ft_reg    <= cur_ft_next;
                crc_reg       <= crc_next;
                out_reg       <= data_res;
                out_valid_reg <= 1'b1;
                if (close)
                begin
                    desc_reg      <= desc_res;
                    desc_pend_reg <= 1'b1;
                end
            end
            else if (out_fire)
            begin
                if (desc_pend_reg)
                begin
                    out_reg       <= desc_reg;
                    desc_pend_reg <= 1'b0;
                end
                else
                begin
                    out_valid_reg <= 1'b0;
                end
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign item_kind      = out_reg.item_kind;
    assign data_byte      = out_reg.data_byte;
    assign frame_type     = out_reg.frame_type;
    assign desc_file_type = out_reg.desc_file_type;
    assign desc_file_size = out_reg.desc_file_size;
    assign seg_start      = out_reg.seg_start;
    assign seg_length     = out_reg.seg_length;
    assign seg_crc        = out_reg.seg_crc;
    assign last           = out_reg.last;

endmodule

@@ sv/fscd_checker.sv @@
// fscd_props: port-level assertions for file_segmenter_crc32_descriptor, bound to it below.
// No package dependencies.
module fscd_props (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic        item_kind,
    input logic [7:0]  data_byte,
    input logic [7:0]  seg_length,
    input logic [31:0] seg_crc,
    input logic        last
);

    // a transfer on the input always shows up as a result the next cycle
    a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("input transfer not followed by a result");

    // a descriptor always ends the results of its byte
    a_desc_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && item_kind |-> last && seg_length != 8'd0 && data_byte == 8'd0)
        else $error("malformed descriptor");

    // a data result that is not last must be followed by a descriptor, not new data
    a_desc_follows: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !item_kind && !last |=> out_valid && item_kind)
        else $error("descriptor missing after closing byte");

    // a data result marked last closes nothing, so no descriptor may follow directly
    a_no_stray_desc: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !item_kind && last |=> !(out_valid && item_kind))
        else $error("descriptor without closing byte");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(seg_crc) && $stable(data_byte))
        else $error("stalled result changed");

endmodule

bind file_segmenter_crc32_descriptor fscd_props u_fscd_props (.*);
